// File: rtl/bbc_pkg.sv
// Package with the shared state encoding and pixel type of the box blur.
`timescale 1ns / 1ps
package bbc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_LAUNCH,
    ST_DIVIDE,
    ST_HOLD
  } bbc_state_t;

  localparam int unsigned CH_W = 8;
  localparam int unsigned PIX_W = 3 * CH_W;
  localparam int unsigned QUOT_STEPS = CH_W;

  typedef logic [PIX_W-1:0] pixel_t;

endpackage

// File: rtl/box_blur_clipped_top.sv
// Top level of the clipped RGB box blur: position control, box sweep, output register.
// An item that produces a result starts a sweep of its clipped box (rows by cols),
// then the drain, launch and divide states and the output register load; in_stall
// holds new items off until the block is idle again. The single line-store read
// port reads one box pixel per cycle. Other items: one per cycle while idle.
// Reset (synchronous, active high) sets width and height to 1024, clears all
// positions and the control state; the line store is not cleared and needs no pass.
`timescale 1ns / 1ps
module box_blur_clipped_top #(
  parameter int unsigned RADIUS    = 6,
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        frame_end
);
  import bbc_pkg::*;

  localparam int unsigned LINE_ROWS = 2 * RADIUS + 2;
  localparam int unsigned DIM       = 2 * RADIUS + 1;
  localparam int unsigned LW        = $clog2(LINE_ROWS);
  localparam int unsigned CW        = $clog2(MAX_WIDTH);
  localparam int unsigned WW        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DW        = $clog2(DIM + 1);
  localparam int unsigned CNT_W     = $clog2(DIM * DIM + 1);
  localparam int unsigned SUM_W     = $clog2(DIM * DIM * 255 + 1);
  localparam int unsigned PW        = 30;
  localparam int unsigned RW        = 17;
  localparam int unsigned AW        = LW + CW;

  localparam logic       CFG_WIDTH  = 1'b0;
  localparam logic       CFG_HEIGHT = 1'b1;

  // Configuration registers.
  logic [10:0] width_reg;
  logic [15:0] height_reg;
  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;

  always_comb begin
    if (width_reg == 11'd0) begin
      w_eff = WW'(1);
    end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_reg);
    end
    h_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
  end

  // Stream positions.
  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col;
  logic [LW-1:0] in_slot;
  logic [PW-1:0] pos;
  logic [15:0]   out_row;
  logic [CW-1:0] out_col;
  logic [LW-1:0] out_slot;

  bbc_state_t state, state_next;

  logic in_fire;
  logic in_frame;
  logic take;
  logic produce;
  logic [PW-1:0] lag;
  logic in_col_wrap;
  logic out_col_wrap;
  logic last;

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign in_frame = in_row < RW'(h_eff);
  // A flush tick that comes while the frame is still being received is dropped.
  assign take     = in_fire && !(req_type && in_frame);
  assign lag      = PW'(RADIUS) * PW'(w_eff) + PW'(RADIUS);
  // The item whose advance moves the position beyond the lag produces a result.
  assign produce  = take && (pos >= lag);
  assign in_col_wrap  = (WW'(in_col) + WW'(1)) >= w_eff;
  assign out_col_wrap = (WW'(out_col) + WW'(1)) >= w_eff;
  assign last = (out_row == h_eff - 16'd1) && (WW'(out_col) == w_eff - WW'(1));

  // Clipped box geometry for the output pixel at the current out position.
  logic [RW-1:0] r0, r1, row_hi, row_up;
  logic [WW:0]   c0, c1, col_hi;
  logic [DW-1:0] nrows, ncols;
  logic [LW-1:0] slot0;
  logic [CNT_W-1:0] count;

  always_comb begin
    r0 = (out_row >= 16'(RADIUS)) ? RW'(out_row) - RW'(RADIUS) : '0;
    row_hi = RW'(out_row) + RW'(RADIUS);
    r1 = (row_hi > RW'(h_eff) - RW'(1)) ? RW'(h_eff) - RW'(1) : row_hi;
    nrows = DW'(r1 - r0 + RW'(1));
    row_up = RW'(out_row) - r0;
    if (RW'(out_slot) >= row_up) begin
      slot0 = LW'(RW'(out_slot) - row_up);
    end else begin
      slot0 = LW'(RW'(out_slot) + RW'(LINE_ROWS) - row_up);
    end
    c0 = ((WW + 1)'(out_col) >= (WW + 1)'(RADIUS)) ?
         (WW + 1)'(out_col) - (WW + 1)'(RADIUS) : '0;
    col_hi = (WW + 1)'(out_col) + (WW + 1)'(RADIUS);
    c1 = (col_hi > (WW + 1)'(w_eff) - (WW + 1)'(1)) ?
         (WW + 1)'(w_eff) - (WW + 1)'(1) : col_hi;
    ncols = DW'(c1 - c0 + (WW + 1)'(1));
    count = CNT_W'(nrows) * CNT_W'(ncols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= 11'd1024;
      height_reg <= 16'd1024;
      in_row   <= '0;
      in_col   <= '0;
      in_slot  <= '0;
      pos      <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_slot <= '0;
    end else if (cfg_we) begin
      // A register write restarts the frame; the stored lines are kept.
      if (cfg_index == CFG_WIDTH) begin
        width_reg <= cfg_data[10:0];
      end else begin
        height_reg <= cfg_data;
      end
      in_row   <= '0;
      in_col   <= '0;
      in_slot  <= '0;
      pos      <= '0;
      out_row  <= '0;
      out_col  <= '0;
      out_slot <= '0;
    end else if (take) begin
      if (produce && last) begin
        in_row   <= '0;
        in_col   <= '0;
        in_slot  <= '0;
        pos      <= '0;
        out_row  <= '0;
        out_col  <= '0;
        out_slot <= '0;
      end else begin
        pos <= pos + PW'(1);
        if (in_col_wrap) begin
          in_col  <= '0;
          in_row  <= in_row + RW'(1);
          in_slot <= (in_slot == LW'(LINE_ROWS - 1)) ? '0 : in_slot + LW'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
        if (produce) begin
          if (out_col_wrap) begin
            out_col  <= '0;
            out_row  <= out_row + 16'd1;
            out_slot <= (out_slot == LW'(LINE_ROWS - 1)) ? '0 : out_slot + LW'(1);
          end else begin
            out_col <= out_col + CW'(1);
          end
        end
      end
    end
  end

  // Box sweep: one line-store read per cycle, row by row.
  logic [LW-1:0] rd_slot;
  logic [CW-1:0] rd_col, col_first;
  logic [DW-1:0] col_cnt, row_cnt, box_cols, box_rows;
  logic [CNT_W-1:0] box_count;
  logic          box_last;
  logic          rd_vld;
  logic          sweep_end;
  pixel_t        rdata;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;

  assign sweep_end = (col_cnt == box_cols - DW'(1)) && (row_cnt == box_rows - DW'(1));

  always_ff @(posedge clk) begin
    if (produce) begin
      rd_slot   <= slot0;
      rd_col    <= CW'(c0);
      col_first <= CW'(c0);
      col_cnt   <= '0;
      row_cnt   <= '0;
      box_cols  <= ncols;
      box_rows  <= nrows;
      box_count <= count;
      box_last  <= last;
    end else if (state == ST_READ) begin
      if (col_cnt == box_cols - DW'(1)) begin
        col_cnt <= '0;
        rd_col  <= col_first;
        row_cnt <= row_cnt + DW'(1);
        rd_slot <= (rd_slot == LW'(LINE_ROWS - 1)) ? '0 : rd_slot + LW'(1);
      end else begin
        col_cnt <= col_cnt + DW'(1);
        rd_col  <= rd_col + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_READ);
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      sum_r <= '0;
      sum_g <= '0;
      sum_b <= '0;
    end else if (rd_vld) begin
      sum_r <= sum_r + SUM_W'(rdata[23:16]);
      sum_g <= sum_g + SUM_W'(rdata[15:8]);
      sum_b <= sum_b + SUM_W'(rdata[7:0]);
    end
  end

  bbc_line_mem #(
    .ADDR_W (AW)
  ) u_mem (
    .clk   (clk),
    .we    (take && in_frame),
    .waddr ({in_slot, in_col}),
    .wdata ({red_in, green_in, blue_in}),
    .raddr ({rd_slot, rd_col}),
    .rdata (rdata)
  );

  logic div_start;
  logic div_done;
  logic [7:0] q_r, q_g, q_b;

  assign div_start = (state == ST_LAUNCH);

  bbc_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sum_r (sum_r),
    .sum_g (sum_g),
    .sum_b (sum_b),
    .count (box_count),
    .done  (div_done),
    .q_r   (q_r),
    .q_g   (q_g),
    .q_b   (q_b)
  );

  // The output register frees when its transfer completes.
  logic out_free;
  logic load_out;

  assign out_free = !out_valid || !out_stall;
  assign load_out = ((state == ST_DIVIDE) && div_done && out_free) ||
                    ((state == ST_HOLD) && out_free);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (produce) state_next = ST_READ;
      ST_READ:   if (sweep_end) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_LAUNCH;
      ST_LAUNCH: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done) state_next = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      red_out   <= q_r;
      green_out <= q_g;
      blue_out  <= q_b;
      frame_end <= box_last;
    end
  end

  a_rdvld_from_read : assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state) == ST_READ)
    else $error("read data valid without a sweep read");

  a_done_in_divide : assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVIDE)
    else $error("divider finished outside the divide state");

  a_load_source : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_DIVIDE || $past(state) == ST_HOLD))
    else $error("output loaded without a finished division");

endmodule

// File: rtl/bbc_line_mem.sv
// Line store memory: one write port and one registered read port.
`timescale 1ns / 1ps
module bbc_line_mem #(
  parameter int unsigned ADDR_W = 14
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  bbc_pkg::pixel_t      wdata,
  input  logic [ADDR_W-1:0]    raddr,
  output bbc_pkg::pixel_t      rdata
);
  import bbc_pkg::*;

  pixel_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bbc_divider.sv
// Three-lane restoring divider that forms the rounded channel averages.
`timescale 1ns / 1ps
module bbc_divider #(
  parameter int unsigned SUM_W = 16,
  parameter int unsigned CNT_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SUM_W-1:0]      sum_r,
  input  logic [SUM_W-1:0]      sum_g,
  input  logic [SUM_W-1:0]      sum_b,
  input  logic [CNT_W-1:0]      count,
  output logic                  done,
  output logic [7:0]            q_r,
  output logic [7:0]            q_g,
  output logic [7:0]            q_b
);
  import bbc_pkg::*;

  localparam int unsigned X_W = SUM_W + CNT_W + 9;

  logic [X_W-1:0] rem [3];
  logic [X_W-1:0] dvs;
  logic [7:0]     quo [3];
  logic [2:0]     step;
  logic           busy;
  logic [X_W-1:0] num [3];

  // The numerator is 2*sum + count and the divisor 2*count; seven left shifts
  // align the divisor with the top quotient bit.
  always_comb begin
    num[0] = X_W'({sum_r, 1'b0}) + X_W'(count);
    num[1] = X_W'({sum_g, 1'b0}) + X_W'(count);
    num[2] = X_W'({sum_b, 1'b0}) + X_W'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'(QUOT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= X_W'({count, 1'b0}) << 7;
      for (int i = 0; i < 3; i++) begin
        rem[i] <= num[i];
        quo[i] <= '0;
      end
    end else if (busy) begin
      dvs <= dvs >> 1;
      for (int i = 0; i < 3; i++) begin
        if (rem[i] >= dvs) begin
          rem[i] <= rem[i] - dvs;
          quo[i] <= {quo[i][6:0], 1'b1};
        end else begin
          quo[i] <= {quo[i][6:0], 1'b0};
        end
      end
    end
  end

  assign q_r = quo[0];
  assign q_g = quo[1];
  assign q_b = quo[2];

endmodule
